// ===== rtl/core/cps_pkg.sv =====
// Shared types and constants of the compacting pool suballocator.
`timescale 1ns / 1ps
`default_nettype none
package cps_pkg;

  localparam logic [31:0] MIN_BLOCK_RESET = 32'd8388608;

  typedef enum logic [2:0] {
    ST_PLACED    = 3'd0,
    ST_KEPT      = 3'd1,
    ST_ZERO      = 3'd2,
    ST_NO_SLOT   = 3'd3,
    ST_FREED     = 3'd4,
    ST_FREE_NONE = 3'd5
  } status_t;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_DECIDE,
    S_COMPACT,
    S_COMPACT_WB,
    S_FILL,
    S_SEARCH,
    S_PLACE,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/cps_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module cps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read on one port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/compacting_pool_suballocator.sv =====
// Top level of the compacting pool suballocator: sequencer, handle store, pool table.
//
// One request is taken at a time; in_tready is low until its result is handed over.
// A free or a resize walks the handle RAM once, reading each handle and writing back the
// slid offset; the pool search then tries the pool slots in order, lowest first.
// One 32-bit subtract/compare unit does every offset slide, the fill decrease on a release
// and the space test.
// The handle tables sit in one RAM that is never cleared; a live bit per handle guards it.
`timescale 1ns / 1ps
`default_nettype none
module compacting_pool_suballocator #(
  parameter int NUM_HANDLES = 64,
  parameter int NUM_POOLS   = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: handle[5:0], buf_target[6], usage_class[7], req_size[39:8]
  input  wire logic [39:0] in_tdata,
  // tuser: req_type
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: status[2:0], pool_index[5:3], region_offset[37:6], region_size[69:38], pad
  output logic      [71:0] out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);

  localparam int HW = $clog2(NUM_HANDLES);
  localparam int PW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int CW = $clog2(NUM_HANDLES + 1);
  localparam int QW = $clog2(NUM_POOLS + 1);
  // Handle RAM word: usage, pool, size, offset
  localparam int RW = 1 + PW + 64;

  cps_pkg::state_t state_r, state_nxt;

  logic [31:0] min_blk_r;
  logic        req_r, tgt_r, use_r, hok_r;
  logic [31:0] sz_r;
  logic [HW-1:0] h_r;

  logic [NUM_HANDLES-1:0] live_r;
  logic [NUM_POOLS-1:0]   open_r;
  logic [1:0]  kind_r [NUM_POOLS];
  logic [31:0] cap_r  [NUM_POOLS];
  logic [31:0] fill_r [NUM_POOLS];

  // Victim region being released
  logic [PW-1:0] vp_r;
  logic [31:0]   voff_r, vsz_r;
  logic          alloc_after_r;

  logic [CW-1:0] k_r;
  logic [QW-1:0] p_r;

  logic [2:0]  o_st_r;
  logic [2:0]  o_pool_r;
  logic [31:0] o_off_r, o_sz_r;

  // RAM port
  logic          ram_we;
  logic [HW-1:0] ram_addr;
  logic [RW-1:0] ram_wdata, ram_rdata;

  logic [31:0]   rd_off, rd_sz;
  logic [PW-1:0] rd_pool;
  logic          rd_use;
  assign rd_off  = ram_rdata[31:0];
  assign rd_sz   = ram_rdata[63:32];
  assign rd_pool = ram_rdata[64 +: PW];
  assign rd_use  = ram_rdata[RW-1];

  cps_ram #(.WIDTH(RW), .DEPTH(NUM_HANDLES)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // Shared subtract unit
  logic [31:0] alu_a, alu_b;
  logic [32:0] alu_d;
  assign alu_d = {1'b0, alu_a} - {1'b0, alu_b};

  logic [PW-1:0] pi;
  assign pi = p_r[PW-1:0];
  logic [HW-1:0] ki;
  assign ki = k_r[HW-1:0];

  always_comb begin
    alu_a = 32'd0;
    alu_b = 32'd0;
    unique case (state_r)
      cps_pkg::S_COMPACT_WB: begin
        alu_a = rd_off;
        alu_b = vsz_r;
      end
      cps_pkg::S_FILL: begin
        alu_a = fill_r[vp_r];
        alu_b = vsz_r;
      end
      cps_pkg::S_SEARCH: begin
        alu_a = cap_r[pi] - fill_r[pi];
        alu_b = sz_r;
      end
      default: begin
        alu_a = 32'd0;
        alu_b = 32'd0;
      end
    endcase
  end

  logic [PW-1:0] free_slot;
  logic          any_free;
  always_comb begin
    free_slot = '0;
    any_free  = 1'b0;
    for (int i = NUM_POOLS - 1; i >= 0; i--) begin
      if (!open_r[i]) begin
        free_slot = PW'(i);
        any_free  = 1'b1;
      end
    end
  end

  // Pool that takes the region: the hit of the search, or the lowest closed slot
  logic [PW-1:0] pp;
  assign pp = (p_r == QW'(NUM_POOLS)) ? free_slot : pi;

  logic search_hit;
  assign search_hit = open_r[pi] && (kind_r[pi] == {use_r, tgt_r}) && !alu_d[32];

  assign in_tready  = (state_r == cps_pkg::S_IDLE);
  assign out_tvalid = (state_r == cps_pkg::S_OUT);
  assign out_tdata  = {2'b00, o_sz_r, o_off_r, o_pool_r, o_st_r};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cps_pkg::S_IDLE:
        if (in_tvalid) state_nxt = cps_pkg::S_LOOK;
      cps_pkg::S_LOOK: state_nxt = cps_pkg::S_DECIDE;
      cps_pkg::S_DECIDE: begin
        priority if (req_r == cps_pkg::REQ_FREE) begin
          state_nxt = (hok_r && live_r[h_r]) ? cps_pkg::S_COMPACT : cps_pkg::S_OUT;
        end else if (sz_r == 32'd0 || !hok_r) begin
          state_nxt = cps_pkg::S_OUT;
        end else if (live_r[h_r]) begin
          state_nxt = (rd_sz == sz_r && rd_use == use_r) ? cps_pkg::S_OUT
                                                         : cps_pkg::S_COMPACT;
        end else begin
          state_nxt = cps_pkg::S_SEARCH;
        end
      end
      cps_pkg::S_COMPACT:
        state_nxt = (k_r == CW'(NUM_HANDLES)) ? cps_pkg::S_FILL : cps_pkg::S_COMPACT_WB;
      cps_pkg::S_COMPACT_WB: state_nxt = cps_pkg::S_COMPACT;
      cps_pkg::S_FILL:
        state_nxt = alloc_after_r ? cps_pkg::S_SEARCH : cps_pkg::S_OUT;
      cps_pkg::S_SEARCH: begin
        if (p_r == QW'(NUM_POOLS)) begin
          state_nxt = any_free ? cps_pkg::S_PLACE : cps_pkg::S_OUT;
        end else if (search_hit) begin
          state_nxt = cps_pkg::S_PLACE;
        end
      end
      cps_pkg::S_PLACE: state_nxt = cps_pkg::S_OUT;
      cps_pkg::S_OUT:
        if (out_tready) state_nxt = cps_pkg::S_IDLE;
      default: state_nxt = cps_pkg::S_IDLE;
    endcase
  end

  // RAM control
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = h_r;
    ram_wdata = ram_rdata;
    unique case (state_r)
      cps_pkg::S_COMPACT: ram_addr = ki;
      cps_pkg::S_COMPACT_WB: begin
        ram_addr = HW'(k_r - CW'(1));
        ram_we   = live_r[ram_addr] && (rd_pool == vp_r) && (rd_off > voff_r);
        ram_wdata = {rd_use, rd_pool, rd_sz, alu_d[31:0]};
      end
      cps_pkg::S_PLACE: begin
        ram_we    = 1'b1;
        ram_wdata = {use_r, pp, sz_r, (p_r == QW'(NUM_POOLS)) ? 32'd0 : fill_r[pi]};
      end
      default: ram_addr = h_r;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= cps_pkg::S_IDLE;
      min_blk_r  <= cps_pkg::MIN_BLOCK_RESET;
      live_r     <= '0;
      open_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) min_blk_r <= cfg_wdata;
      unique case (state_r)
        cps_pkg::S_IDLE: begin
          if (in_tvalid) begin
            req_r <= in_tuser;
            h_r   <= HW'(in_tdata[5:0]);
            hok_r <= ({26'd0, in_tdata[5:0]} < 32'(NUM_HANDLES));
            tgt_r <= in_tdata[6];
            use_r <= in_tdata[7];
            sz_r  <= in_tdata[39:8];
          end
        end
        cps_pkg::S_LOOK: begin
          o_st_r   <= cps_pkg::ST_NO_SLOT;
          o_pool_r <= 3'd0;
          o_off_r  <= 32'd0;
          o_sz_r   <= 32'd0;
        end
        cps_pkg::S_DECIDE: begin
          vp_r   <= rd_pool;
          voff_r <= rd_off;
          vsz_r  <= rd_sz;
          k_r    <= '0;
          p_r    <= '0;
          alloc_after_r <= (req_r == cps_pkg::REQ_ALLOC);
          priority if (req_r == cps_pkg::REQ_FREE) begin
            if (hok_r && live_r[h_r]) begin
              live_r[h_r] <= 1'b0;
              o_st_r  <= cps_pkg::ST_FREED;
              o_off_r <= rd_off;
              o_sz_r  <= rd_sz;
            end else begin
              o_st_r <= cps_pkg::ST_FREE_NONE;
            end
          end else if (sz_r == 32'd0) begin
            o_st_r <= cps_pkg::ST_ZERO;
          end else if (!hok_r) begin
            o_st_r <= cps_pkg::ST_NO_SLOT;
          end else if (live_r[h_r] && rd_sz == sz_r && rd_use == use_r) begin
            o_st_r   <= cps_pkg::ST_KEPT;
            o_pool_r <= 3'(rd_pool);
            o_off_r  <= rd_off;
            o_sz_r   <= sz_r;
          end else if (live_r[h_r]) begin
            live_r[h_r] <= 1'b0;
          end
        end
        cps_pkg::S_COMPACT: begin
          if (k_r != CW'(NUM_HANDLES)) k_r <= k_r + CW'(1);
        end
        cps_pkg::S_FILL: begin
          fill_r[vp_r] <= alu_d[32] ? 32'd0 : alu_d[31:0];
        end
        cps_pkg::S_SEARCH: begin
          // Hold the index at NUM_POOLS once every open pool has been tried
          if (p_r != QW'(NUM_POOLS) && !search_hit) begin
            p_r <= p_r + QW'(1);
          end
        end
        cps_pkg::S_PLACE: begin
          live_r[h_r] <= 1'b1;
          o_st_r      <= cps_pkg::ST_PLACED;
          o_pool_r    <= 3'(pi);
          o_sz_r      <= sz_r;
          if (p_r == QW'(NUM_POOLS)) begin
            // Open a fresh pool at the lowest closed slot
            open_r[free_slot] <= 1'b1;
            kind_r[free_slot] <= {use_r, tgt_r};
            cap_r[free_slot]  <= (sz_r > min_blk_r) ? sz_r : min_blk_r;
            fill_r[free_slot] <= sz_r;
            o_pool_r          <= 3'(free_slot);
            o_off_r           <= 32'd0;
          end else begin
            fill_r[pi] <= fill_r[pi] + sz_r;
            o_off_r    <= fill_r[pi];
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_kept_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cps_pkg::S_PLACE) |=> live_r[h_r]) else $error("placed handle not live");
`endif

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for the compacting pool suballocator.
`timescale 1ns / 1ps
module tb_top;

  localparam int HANDLES   = 64;
  localparam int POOLS     = 8;
  localparam int LIMIT     = 3000000;
  localparam int END_WAIT  = 300;

  typedef struct packed {
    cps_pkg::status_t st;
    logic [2:0]  pool;
    logic [31:0] off;
    logic [31:0] size;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  compacting_pool_suballocator #(.NUM_HANDLES(HANDLES), .NUM_POOLS(POOLS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the allocator state
  logic        h_live [HANDLES];
  logic [2:0]  h_pool [HANDLES];
  logic [31:0] h_off [HANDLES];
  logic [31:0] h_size [HANDLES];
  logic        h_use [HANDLES];
  logic        p_open [POOLS];
  logic [1:0]  p_kind [POOLS];
  logic [31:0] p_cap [POOLS];
  logic [31:0] p_fill [POOLS];
  logic [31:0] min_block = cps_pkg::MIN_BLOCK_RESET;

  result_t pending_results[$];
  int      errors = 0;
  int      sent = 0;
  int      checked = 0;
  int      status_seen [8];
  int      cycles = 0;
  bit      calm_in = 1'b0;
  bit      calm_out = 1'b0;
  int      hold_seq = 0;
  int      hold_len = 0;

  // Remove a region and slide the later regions of its pool down
  function automatic void release_handle(int h);
    logic [2:0]  p;
    logic [31:0] o;
    logic [31:0] s;
    p = h_pool[h];
    o = h_off[h];
    s = h_size[h];
    h_live[h] = 1'b0;
    for (int k = 0; k < HANDLES; k++) begin
      if (h_live[k] && h_pool[k] == p && h_off[k] > o) h_off[k] -= s;
    end
    p_fill[p] = (p_fill[p] >= s) ? p_fill[p] - s : 32'd0;
  endfunction

  // Work out the answer to one request and advance the shadow state
  function automatic result_t apply_request(logic rt, logic [5:0] h, logic tgt, logic use_c,
                                            logic [31:0] sz);
    result_t    r;
    int         p;
    logic [1:0] kind;
    r.st = cps_pkg::ST_ZERO;
    r.pool = '0;
    r.off = '0;
    r.size = '0;
    kind = {use_c, tgt};
    if (rt == cps_pkg::REQ_FREE) begin
      if (!h_live[h]) begin
        r.st = cps_pkg::ST_FREE_NONE;
      end else begin
        r.st = cps_pkg::ST_FREED;
        r.off = h_off[h];
        r.size = h_size[h];
        release_handle(h);
      end
      return r;
    end
    if (sz == 0) return r;
    if (h_live[h]) begin
      if (h_size[h] == sz && h_use[h] == use_c) begin
        r.st = cps_pkg::ST_KEPT;
        r.pool = h_pool[h];
        r.off = h_off[h];
        r.size = sz;
        return r;
      end
      release_handle(h);
    end
    p = -1;
    for (int i = 0; i < POOLS; i++) begin
      if (p < 0 && p_open[i] && p_kind[i] == kind && p_cap[i] - p_fill[i] >= sz) p = i;
    end
    if (p < 0) begin
      for (int i = 0; i < POOLS; i++) begin
        if (p < 0 && !p_open[i]) p = i;
      end
      if (p < 0) begin
        r.st = cps_pkg::ST_NO_SLOT;
        return r;
      end
      p_open[p] = 1'b1;
      p_kind[p] = kind;
      p_cap[p] = (sz > min_block) ? sz : min_block;
      p_fill[p] = '0;
    end
    h_live[h] = 1'b1;
    h_pool[h] = p[2:0];
    h_off[h] = p_fill[p];
    h_size[h] = sz;
    h_use[h] = use_c;
    p_fill[p] += sz;
    r.st = cps_pkg::ST_PLACED;
    r.pool = p[2:0];
    r.off = h_off[h];
    r.size = sz;
    return r;
  endfunction

  // Offer one request, wait for its transaction, then idle for a drawn gap
  task automatic send_request(logic rt, logic [5:0] h, logic tgt, logic use_c, logic [31:0] sz);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser <= rt;
    in_tdata <= {sz, use_c, tgt, h};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results = {pending_results, apply_request(rt, h, tgt, use_c, sz)};
    sent++;
    gap = calm_in ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_min_block(logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    min_block = v;
    @(posedge clk);
  endtask

  // Receiver: random stalls per transaction, long hold-offs on request, and the check
  always @(posedge clk) begin
    static int stall = 0;
    static int hold = 0;
    static int hold_seen = 0;
    result_t exp_r;
    logic [2:0] act_st;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        act_st = out_tdata[2:0];
        status_seen[act_st]++;
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected, actual %h", $time, out_tdata);
          errors++;
        end else begin
          exp_r = pending_results.pop_front();
          checked++;
          if (act_st != exp_r.st) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.st, act_st);
            errors++;
          end
          if (out_tdata[5:3] != exp_r.pool) begin
            $display("%0t: pool expected %0d actual %0d", $time, exp_r.pool, out_tdata[5:3]);
            errors++;
          end
          if (out_tdata[37:6] != exp_r.off) begin
            $display("%0t: offset expected %h actual %h", $time, exp_r.off, out_tdata[37:6]);
            errors++;
          end
          if (out_tdata[69:38] != exp_r.size) begin
            $display("%0t: size expected %h actual %h", $time, exp_r.size, out_tdata[69:38]);
            errors++;
          end
        end
        stall = calm_out ? 0 : $urandom_range(0, 12);
      end
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold = hold_len;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Run guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    write_min_block(32'd1);
    send_request(cps_pkg::REQ_ALLOC, 6'd3, 1'b0, 1'b0, 32'd0);
    send_request(cps_pkg::REQ_FREE, 6'd5, 1'b0, 1'b0, 32'd0);
    send_request(cps_pkg::REQ_ALLOC, 6'd0, 1'b0, 1'b0, 32'd1);
    send_request(cps_pkg::REQ_ALLOC, 6'd0, 1'b0, 1'b0, 32'd1);
    // keep ignores the target
    send_request(cps_pkg::REQ_ALLOC, 6'd0, 1'b1, 1'b0, 32'd1);
    send_request(cps_pkg::REQ_ALLOC, 6'd1, 1'b0, 1'b1, 32'd100);
    send_request(cps_pkg::REQ_ALLOC, 6'd2, 1'b0, 1'b0, 32'd16);
    send_request(cps_pkg::REQ_ALLOC, 6'd63, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_request(cps_pkg::REQ_ALLOC, 6'd62, 1'b1, 1'b0, 32'h8000_0000);
    send_request(cps_pkg::REQ_ALLOC, 6'd63, 1'b1, 1'b1, 32'd0);
    // resize and usage change release the old region first
    send_request(cps_pkg::REQ_ALLOC, 6'd0, 1'b0, 1'b0, 32'd2);
    send_request(cps_pkg::REQ_ALLOC, 6'd2, 1'b0, 1'b1, 32'd16);
    send_request(cps_pkg::REQ_FREE, 6'd0, 1'b0, 1'b0, 32'd0);
    send_request(cps_pkg::REQ_FREE, 6'd0, 1'b0, 1'b0, 32'd0);
    send_request(cps_pkg::REQ_FREE, 6'd62, 1'b0, 1'b0, 32'd0);
    // empty pool stays open and is reused
    send_request(cps_pkg::REQ_ALLOC, 6'd61, 1'b1, 1'b0, 32'h4000_0000);
    send_request(cps_pkg::REQ_FREE, 6'd1, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_request(cps_pkg::REQ_FREE, 6'd2, 1'b0, 1'b0, 32'd0);
    wait_drained();
  endtask

  task automatic test_random(int count, logic [31:0] mb, bit with_hold);
    logic       rt;
    logic [5:0] h;
    logic [31:0] sz;
    int         pick;
    write_min_block(mb);
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        calm_in = ($urandom_range(0, 3) == 0);
        calm_out = ($urandom_range(0, 3) == 0);
      end
      if (with_hold && n == count / 3) begin
        hold_len = 400;
        hold_seq++;
      end
      if (n == count / 2) wait_drained();
      rt = ($urandom_range(0, 9) < 3) ? cps_pkg::REQ_FREE : cps_pkg::REQ_ALLOC;
      h = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 15)) : 6'($urandom_range(0, 63));
      pick = $urandom_range(0, 99);
      if (pick < 5) sz = 32'd0;
      else if (pick < 15) sz = $urandom;
      else if (pick < 35 && h_live[h]) sz = h_size[h];
      else if (pick < 60) sz = 32'd64 << $urandom_range(0, 6);
      else sz = $urandom_range(1, 1 << 20);
      send_request(rt, h, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), sz);
    end
    calm_in = 1'b0;
    calm_out = 1'b0;
    wait_drained();
  endtask

  // Use up every pool slot, then resize into a kind that cannot be placed
  task automatic test_exhaustion();
    write_min_block(32'hFFFF_FFFF);
    for (int i = 0; i < 10; i++) begin
      send_request(cps_pkg::REQ_ALLOC, 6'(48 + i), 1'b1, 1'b1, 32'hFFFF_FFFF);
    end
    send_request(cps_pkg::REQ_ALLOC, 6'd48, 1'b1, 1'b0, 32'hFFFF_FFFF);
    send_request(cps_pkg::REQ_FREE, 6'd48, 1'b0, 1'b0, 32'd0);
    send_request(cps_pkg::REQ_ALLOC, 6'd49, 1'b0, 1'b1, 32'hFFFF_FFFE);
    wait_drained();
    write_min_block(cps_pkg::MIN_BLOCK_RESET);
  endtask

  initial begin
    for (int i = 0; i < HANDLES; i++) begin
      h_live[i] = 1'b0;
      h_pool[i] = '0;
      h_off[i] = '0;
      h_size[i] = '0;
      h_use[i] = 1'b0;
    end
    for (int i = 0; i < POOLS; i++) begin
      p_open[i] = 1'b0;
      p_kind[i] = '0;
      p_cap[i] = '0;
      p_fill[i] = '0;
    end
    for (int i = 0; i < 8; i++) status_seen[i] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(500, cps_pkg::MIN_BLOCK_RESET, 1'b1);
    test_random(500, 32'd1, 1'b0);
    test_random(520, 32'hFFFF_FFFF, 1'b1);
    test_exhaustion();
    repeat (END_WAIT) @(posedge clk);
    $display("Sent %0d requests, checked %0d results over three min_block settings.",
             sent, checked);
    $display("Placed %0d, kept %0d, zero %0d, no slot %0d, freed %0d, free unused %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
